// ===== hdl/ismet_pkg.sv =====
package ismet_pkg;

    localparam int COORD_W  = 5;
    localparam int RAND_W   = 16;
    localparam int THRESH_W = 16;
    localparam int DE_W     = 5;
    localparam int ENERGY_W = 13;
    localparam int MAGNET_W = 12;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam logic ACT_FLIP  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic accept;   // capture beat, read center and upper rows
        logic rd_down;  // read lower row
        logic commit;   // decide, write back, load result
    } t_dp_cmd;

endpackage

// ===== hdl/ismet_ctrl.sv =====
module ismet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ismet_pkg::t_dp_cmd o_cmd
);

    ismet_pkg::t_state r_state;
    ismet_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ismet_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ismet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ismet_pkg::S_FETCH;
                end
            end
            ismet_pkg::S_FETCH: begin
                o_cmd.rd_down = 1'b1;
                n_state       = ismet_pkg::S_EXEC;
            end
            ismet_pkg::S_EXEC: begin
                // hold until the result register can take the beat
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ismet_pkg::S_IDLE;
                end
            end
            default: n_state = ismet_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_fetch_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ismet_pkg::S_FETCH |=> r_state == ismet_pkg::S_EXEC)
        else $error("fetch not followed by exec");

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ismet_pkg::S_EXEC && r_out_valid && !i_out_ready)
        |=> (r_state == ismet_pkg::S_EXEC && r_out_valid))
        else $error("result overwritten while stalled");

endmodule

// ===== hdl/ismet_datapath.sv =====
module ismet_datapath #(
    parameter int SIDE = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ismet_pkg::t_dp_cmd                     i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [ismet_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [ismet_pkg::THRESH_W-1:0]         i_cfg_wdata,
    input  logic                                   i_action,
    input  logic [ismet_pkg::COORD_W-1:0]          i_site_col,
    input  logic [ismet_pkg::COORD_W-1:0]          i_site_row,
    input  logic [ismet_pkg::RAND_W-1:0]           i_rand_value,
    input  logic                                   i_spin_in,
    output logic                                   o_accepted,
    output logic signed [ismet_pkg::DE_W-1:0]      o_delta_energy,
    output logic signed [ismet_pkg::ENERGY_W-1:0]  o_energy_out,
    output logic signed [ismet_pkg::MAGNET_W-1:0]  o_magnet_out,
    output logic [ismet_pkg::COUNT_W-1:0]          o_accept_total
);

    localparam int IDX_W     = $clog2(SIDE);
    localparam int NUM_COORD = 2 ** ismet_pkg::COORD_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIDE - 1);
    localparam logic signed [ismet_pkg::ENERGY_W-1:0] ENERGY_INIT =
        ismet_pkg::ENERGY_W'(-2 * SIDE * SIDE);
    localparam logic signed [ismet_pkg::MAGNET_W-1:0] MAGNET_INIT =
        ismet_pkg::MAGNET_W'(SIDE * SIDE);
    localparam logic signed [ismet_pkg::MAGNET_W-1:0] MAG_STEP = ismet_pkg::MAGNET_W'(2);
    localparam logic [ismet_pkg::DE_W-1:0] DE_FOUR  = ismet_pkg::DE_W'(4);
    localparam logic [ismet_pkg::DE_W-1:0] DE_EIGHT = ismet_pkg::DE_W'(8);

    // coordinate wrap table, built at elaboration
    logic [IDX_W-1:0] w_wrap [NUM_COORD];
    for (genvar g = 0; g < NUM_COORD; g++) begin : g_wrap
        assign w_wrap[g] = IDX_W'(g % SIDE);
    end

    // configuration
    logic [ismet_pkg::THRESH_W-1:0] r_thresh_four;
    logic [ismet_pkg::THRESH_W-1:0] r_thresh_eight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_four  <= '1;
            r_thresh_eight <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ismet_pkg::REG_THRESH_FOUR:  r_thresh_four  <= i_cfg_wdata;
                ismet_pkg::REG_THRESH_EIGHT: r_thresh_eight <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured item
    logic                          r_action;
    logic                          r_spin;
    logic [ismet_pkg::RAND_W-1:0]  r_rand;
    logic [IDX_W-1:0]              r_col;
    logic [IDX_W-1:0]              r_row;
    logic [IDX_W-1:0]              r_down_row;

    logic [IDX_W-1:0] w_row_in;
    logic [IDX_W-1:0] w_up_in;
    logic [IDX_W-1:0] w_down_in;

    assign w_row_in  = w_wrap[i_site_row];
    assign w_up_in   = (w_row_in == '0) ? IDX_LAST : w_row_in - IDX_W'(1);
    assign w_down_in = (w_row_in == IDX_LAST) ? '0 : w_row_in + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_action;
            r_spin     <= i_spin_in;
            r_rand     <= i_rand_value;
            r_col      <= w_wrap[i_site_col];
            r_row      <= w_row_in;
            r_down_row <= w_down_in;
        end
    end

    // lattice memory, one row per word; a row never written reads as all up
    logic [SIDE-1:0] r_mem [SIDE];
    logic [SIDE-1:0] r_row_ok;
    logic [SIDE-1:0] r_rd_a;
    logic [SIDE-1:0] r_rd_b;
    logic            r_rd_a_ok;
    logic            r_rd_b_ok;
    logic [IDX_W-1:0] w_addr_a;
    logic            w_rd_a_en;
    logic [SIDE-1:0] w_word_a;
    logic [SIDE-1:0] w_word_b;
    logic [SIDE-1:0] w_wr_word;
    logic            w_change;

    assign w_addr_a  = i_cmd.accept ? w_row_in : r_down_row;
    assign w_rd_a_en = i_cmd.accept || i_cmd.rd_down;
    assign w_word_a  = r_rd_a_ok ? r_rd_a : '1;
    assign w_word_b  = r_rd_b_ok ? r_rd_b : '1;

    always_ff @(posedge i_clk) begin
        if (w_rd_a_en) begin
            r_rd_a    <= r_mem[w_addr_a];
            r_rd_a_ok <= r_row_ok[w_addr_a];
        end
        if (i_cmd.accept) begin
            r_rd_b    <= r_mem[w_up_in];
            r_rd_b_ok <= r_row_ok[w_up_in];
        end
        if (i_cmd.commit) begin
            r_mem[r_row] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (i_cmd.commit) begin
            r_row_ok[r_row] <= 1'b1;
        end
    end

    // center row and upper neighbor, held from the first read
    logic [SIDE-1:0] r_center;
    logic            r_up_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_down) begin
            r_center <= w_word_a;
            r_up_bit <= w_word_b[r_col];
        end
    end

    // energy change and decision
    logic [IDX_W-1:0]                   w_left;
    logic [IDX_W-1:0]                   w_right;
    logic                               w_s;
    logic [2:0]                         w_ups;
    logic [ismet_pkg::DE_W-1:0]         w_de;
    logic                               w_acc;
    logic [ismet_pkg::DE_W-1:0]         w_shown;

    assign w_left  = (r_col == '0) ? IDX_LAST : r_col - IDX_W'(1);
    assign w_right = (r_col == IDX_LAST) ? '0 : r_col + IDX_W'(1);
    assign w_s     = r_center[r_col];
    assign w_ups   = 3'(r_center[w_left]) + 3'(r_center[w_right]) + 3'(r_up_bit)
                   + 3'(w_word_a[r_col]);
    // spin up: 4*ups - 8, spin down: 8 - 4*ups
    assign w_de    = w_s ? ({w_ups, 2'b00} - DE_EIGHT) : (DE_EIGHT - {w_ups, 2'b00});

    always_comb begin
        w_acc    = 1'b1;
        w_change = 1'b0;
        w_shown  = w_de;
        if (r_action == ismet_pkg::ACT_FLIP) begin
            priority if (w_de[ismet_pkg::DE_W-1] || w_de == '0) w_acc = 1'b1;
            else if (w_de == DE_FOUR)  w_acc = (r_rand <= r_thresh_four);
            else if (w_de == DE_EIGHT) w_acc = (r_rand <= r_thresh_eight);
            else                       w_acc = 1'b0;
            w_change = w_acc;
        end else begin
            w_change = (w_s != r_spin);
            if (!w_change) begin
                w_shown = '0;
            end
        end
    end

    always_comb begin
        w_wr_word = r_center;
        w_wr_word[r_col] = w_s ^ w_change;
    end

    // running totals
    logic signed [ismet_pkg::ENERGY_W-1:0] r_energy;
    logic signed [ismet_pkg::ENERGY_W-1:0] n_energy;
    logic signed [ismet_pkg::MAGNET_W-1:0] r_magnet;
    logic signed [ismet_pkg::MAGNET_W-1:0] n_magnet;
    logic [ismet_pkg::COUNT_W-1:0]         r_count;
    logic [ismet_pkg::COUNT_W-1:0]         n_count;
    logic                                  w_counted;

    assign w_counted = w_acc && (r_action == ismet_pkg::ACT_FLIP);

    always_comb begin
        n_energy = r_energy;
        n_magnet = r_magnet;
        n_count  = r_count;
        if (w_change) begin
            n_energy = r_energy + ismet_pkg::ENERGY_W'(signed'(w_de));
            n_magnet = w_s ? r_magnet - MAG_STEP : r_magnet + MAG_STEP;
        end
        if (w_counted) begin
            n_count = r_count + ismet_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= ENERGY_INIT;
            r_magnet <= MAGNET_INIT;
            r_count  <= '0;
        end else if (i_cmd.commit) begin
            r_energy <= n_energy;
            r_magnet <= n_magnet;
            r_count  <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_accepted     <= w_acc;
            o_delta_energy <= w_shown;
            o_energy_out   <= n_energy;
            o_magnet_out   <= n_magnet;
            o_accept_total <= n_count;
        end
    end

    // energy moves in steps of four from its reset value
    a_energy_mult4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_energy[1:0] == ENERGY_INIT[1:0])
        else $error("energy left its step of four");

    a_magnet_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_magnet[0] == MAGNET_INIT[0])
        else $error("magnetization parity broken");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_counted) |=> r_count == $past(r_count) + ismet_pkg::COUNT_W'(1))
        else $error("accept counter did not advance");

    a_write_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_action == ismet_pkg::ACT_WRITE) |=> $stable(r_count))
        else $error("spin write changed accept counter");

endmodule

// ===== hdl/ising_metropolis_spin_flip.sv =====
// Metropolis spin-flip engine on a SIDE x SIDE periodic Ising lattice.
// Input channel (s_axis): one beat per item. tuser carries the action
// (flip attempt or spin write); tdata carries the site, the 16-bit random
// value and the spin to write. Output channel (m_axis): one result beat per
// input beat, in order, with the accept flag, dE, the running energy and
// magnetization and the accept counter.
// Configuration: i_cfg_we writes register i_cfg_addr (0 = threshold for
// dE 4, 1 = threshold for dE 8) at the clock edge; write only while idle.
// Sequence: an input beat is taken in IDLE; the engine then passes through
// FETCH and EXEC, and no new item is taken until the result is loaded.
// The lattice holds one row per memory word: the site row and the row above
// are read together, the row below in the next cycle, and the row is
// written back in EXEC, once the output register can take the result.
// Reset: all spins up, energy -2*SIDE*SIDE, magnetization SIDE*SIDE,
// counter zero, thresholds 65535. Per-row valid bits stand in for the
// all-up lattice, so no clearing pass is needed.
// Stall: a finished result waits in the output register; the next input
// beat is still taken, and its write-back waits until the result drains.
module ising_metropolis_spin_flip #(
    parameter int SIDE = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ismet_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [ismet_pkg::THRESH_W-1:0]      i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // site_col[4:0], site_row[9:5], rand_value[25:10], spin_in[26]
    input  logic [ismet_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted[0], delta_energy[5:1], energy_out[18:6], magnet_out[30:19],
    // accept_total[62:31]
    output logic [ismet_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    ismet_pkg::t_dp_cmd w_cmd;

    logic                                  w_accepted;
    logic signed [ismet_pkg::DE_W-1:0]     w_delta_energy;
    logic signed [ismet_pkg::ENERGY_W-1:0] w_energy_out;
    logic signed [ismet_pkg::MAGNET_W-1:0] w_magnet_out;
    logic [ismet_pkg::COUNT_W-1:0]         w_accept_total;

    ismet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    ismet_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (s_axis_tuser),
        .i_site_col     (s_axis_tdata[4:0]),
        .i_site_row     (s_axis_tdata[9:5]),
        .i_rand_value   (s_axis_tdata[25:10]),
        .i_spin_in      (s_axis_tdata[26]),
        .o_accepted     (w_accepted),
        .o_delta_energy (w_delta_energy),
        .o_energy_out   (w_energy_out),
        .o_magnet_out   (w_magnet_out),
        .o_accept_total (w_accept_total)
    );

    assign m_axis_tdata = {1'b0, w_accept_total, w_magnet_out, w_energy_out,
                           w_delta_energy, w_accepted};

endmodule
